### src/bhct_pkg.sv
// Shared types, constants and helper functions of the ball hypothesis circle tracker.
`timescale 1ns / 1ps
package bhct_pkg;

    localparam int MAX_CIRCLES = 64;
    localparam int COORD_BITS  = 16;
    localparam int CERT_BITS   = 16;
    localparam int IDX_W       = $clog2(MAX_CIRCLES);
    localparam int CNT_W       = $clog2(MAX_CIRCLES + 1);
    localparam int RAD_W       = 15;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int REQ_DEPTH   = 2;
    localparam int REQ_PTR_W   = $clog2(REQ_DEPTH);

    // register reset values
    localparam logic [CERT_BITS-1:0] DECAY_RESET     = CERT_BITS'(13521);
    localparam logic [RAD_W-1:0]     RADIUS_RESET    = RAD_W'(1372);
    localparam logic [CERT_BITS-1:0] THRESHOLD_RESET = CERT_BITS'(1311);

    // 1.0 in certainty units, one bit wider than a certainty
    localparam logic [CERT_BITS:0] CERT_ONE  = {1'b1, {CERT_BITS{1'b0}}};
    localparam logic [CERT_BITS:0] CERT_MAXV = {1'b0, {CERT_BITS{1'b1}}};

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LOSS_RATE      = 2'd0,
        CFG_MERGE_RADIUS   = 2'd1,
        CFG_DROP_THRESHOLD = 2'd2,
        CFG_UNUSED         = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [CERT_BITS-1:0] loss_rate;
        logic [RAD_W-1:0]     merge_radius;
        logic [CERT_BITS-1:0] drop_threshold;
    } t_cfg;

    // one frame's update request from the front end
    typedef struct packed {
        logic                  has_obs;
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
    } t_frame_req;

    typedef struct packed {
        logic [CERT_BITS-1:0]  cert;
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
    } t_circle;

    typedef struct packed {
        logic [COORD_BITS-1:0] est_x;
        logic [COORD_BITS-1:0] est_y;
        logic [CNT_W-1:0]      live_circles;
        logic                  evicted;
    } t_result;

    typedef enum logic [3:0] {
        S_IDLE,
        S_P1_RD,
        S_P1_DIST,
        S_P1_SQ,
        S_P1_CMP,
        S_P1_MUL,
        S_P1_WB,
        S_P2_RD,
        S_P2_CMP,
        S_INS
    } t_back_state;

    localparam t_circle RESET_CIRCLE = '{cert: THRESHOLD_RESET, x: '0, y: '0};

    // Truncating fractional product; operands are at most 1.0
    function automatic logic [CERT_BITS:0] mul_frac(input logic [CERT_BITS:0] a,
                                                    input logic [CERT_BITS:0] b);
        logic [2*CERT_BITS-1:0] p;
        p = a[CERT_BITS-1:0] * b[CERT_BITS-1:0];
        if (a == CERT_ONE) begin
            return b;
        end else if (b == CERT_ONE) begin
            return a;
        end
        return {1'b0, p[2*CERT_BITS-1:CERT_BITS]};
    endfunction

    // (x, y) lexicographic signed less-than
    function automatic logic pt_less(input logic [COORD_BITS-1:0] ax,
                                     input logic [COORD_BITS-1:0] ay,
                                     input logic [COORD_BITS-1:0] bx,
                                     input logic [COORD_BITS-1:0] by);
        return ($signed(ax) < $signed(bx)) ||
               ((ax == bx) && ($signed(ay) < $signed(by)));
    endfunction

    // ordering by certainty, then position
    function automatic logic key_less(input t_circle a, input t_circle b);
        return (a.cert < b.cert) ||
               ((a.cert == b.cert) && pt_less(a.x, a.y, b.x, b.y));
    endfunction

endpackage

### src/bhct_front.sv
// Front end: keeps the frame's most confident observation and emits a frame request.
`timescale 1ns / 1ps
module bhct_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_accept,
    input  logic                            i_has_obs,
    input  logic [bhct_pkg::CERT_BITS-1:0]  i_obs_conf,
    input  logic [bhct_pkg::COORD_BITS-1:0] i_obs_x,
    input  logic [bhct_pkg::COORD_BITS-1:0] i_obs_y,
    input  logic                            i_frame_end,
    output logic                            o_req_push,
    output bhct_pkg::t_frame_req            o_req
);

    logic                            r_have_best;
    logic [bhct_pkg::CERT_BITS-1:0]  r_best_conf;
    logic [bhct_pkg::COORD_BITS-1:0] r_best_x;
    logic [bhct_pkg::COORD_BITS-1:0] r_best_y;

    logic                            n_have_best;
    logic [bhct_pkg::CERT_BITS-1:0]  n_best_conf;
    logic [bhct_pkg::COORD_BITS-1:0] n_best_x;
    logic [bhct_pkg::COORD_BITS-1:0] n_best_y;
    logic                            w_take;

    // higher confidence wins, ties to the larger point
    always_comb begin
        w_take = i_has_obs && (!r_have_best || (i_obs_conf > r_best_conf) ||
                 ((i_obs_conf == r_best_conf) &&
                  bhct_pkg::pt_less(r_best_x, r_best_y, i_obs_x, i_obs_y)));
        n_have_best = r_have_best || w_take;
        n_best_conf = w_take ? i_obs_conf : r_best_conf;
        n_best_x    = w_take ? i_obs_x : r_best_x;
        n_best_y    = w_take ? i_obs_y : r_best_y;
    end

    assign o_req_push  = i_accept && i_frame_end;
    assign o_req.has_obs = n_have_best;
    assign o_req.x       = n_best_x;
    assign o_req.y       = n_best_y;

    // best tracker, cleared at frame end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have_best <= 1'b0;
            r_best_conf <= '0;
            r_best_x    <= '0;
            r_best_y    <= '0;
        end else if (i_accept) begin
            if (i_frame_end) begin
                r_have_best <= 1'b0;
                r_best_conf <= '0;
                r_best_x    <= '0;
                r_best_y    <= '0;
            end else begin
                r_have_best <= n_have_best;
                r_best_conf <= n_best_conf;
                r_best_x    <= n_best_x;
                r_best_y    <= n_best_y;
            end
        end
    end

endmodule

### src/bhct_req_queue.sv
// Short queue of frame requests between the front end and the circle engine.
`timescale 1ns / 1ps
module bhct_req_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  bhct_pkg::t_frame_req i_req,
    output logic                 o_full,
    input  logic                 i_pop,
    output logic                 o_valid,
    output bhct_pkg::t_frame_req o_req
);

    localparam int CNT_QW = $clog2(bhct_pkg::REQ_DEPTH + 1);

    bhct_pkg::t_frame_req             r_slots [bhct_pkg::REQ_DEPTH];
    logic [bhct_pkg::REQ_PTR_W-1:0]   r_wr_ptr;
    logic [bhct_pkg::REQ_PTR_W-1:0]   r_rd_ptr;
    logic [CNT_QW-1:0]                r_count;
    logic                             w_push;
    logic                             w_pop;

    assign o_full  = (r_count == CNT_QW'(bhct_pkg::REQ_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_req   = r_slots[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    // pointer and fill tracking
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == bhct_pkg::REQ_PTR_W'(bhct_pkg::REQ_DEPTH - 1)) ?
                            '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == bhct_pkg::REQ_PTR_W'(bhct_pkg::REQ_DEPTH - 1)) ?
                            '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // payload storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slots[r_wr_ptr] <= i_req;
        end
    end

endmodule

### src/bhct_back.sv
// Circle engine: merge/decay pass, then count/select pass, then insertion.
`timescale 1ns / 1ps
module bhct_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  bhct_pkg::t_cfg       i_cfg,
    input  logic                 i_req_valid,
    input  bhct_pkg::t_frame_req i_req,
    output logic                 o_req_pop,
    output logic                 o_res_valid,
    output bhct_pkg::t_result    o_res,
    input  logic                 i_res_pop
);

    localparam int CB = bhct_pkg::CERT_BITS;
    localparam int XB = bhct_pkg::COORD_BITS;
    localparam int IW = bhct_pkg::IDX_W;
    localparam int RW = bhct_pkg::RAD_W;

    bhct_pkg::t_back_state r_state, n_state;

    // circle memory and valid bits
    bhct_pkg::t_circle            r_mem [bhct_pkg::MAX_CIRCLES];
    bhct_pkg::t_circle            r_rd;
    logic [bhct_pkg::MAX_CIRCLES-1:0] r_valid;
    logic                         r_e0_init;

    logic [IW-1:0]                r_idx;
    logic                         r_has;
    logic [XB-1:0]                r_bx;
    logic [XB-1:0]                r_by;
    logic [CB:0]                  r_keep;
    logic [CB:0]                  r_recip;
    logic [2*RW-1:0]              r_rad2;
    bhct_pkg::t_circle            r_ent;
    logic                         r_far;
    logic [RW-1:0]                r_ax;
    logic [RW-1:0]                r_ay;
    logic [2*RW-1:0]              r_sqx;
    logic [2*RW-1:0]              r_sqy;
    logic                         r_inside;
    logic [CB-1:0]                r_newc;

    logic [bhct_pkg::CNT_W-1:0]   r_cnt;
    logic                         r_free_found;
    logic [IW-1:0]                r_free_idx;
    logic                         r_max_found;
    bhct_pkg::t_circle            r_max;
    logic                         r_min_found;
    bhct_pkg::t_circle            r_min;
    logic [IW-1:0]                r_min_idx;

    logic                         r_res_valid;
    bhct_pkg::t_result            r_res;

    bhct_pkg::t_circle            w_ent;
    logic                         w_last;
    logic signed [XB:0]           w_dx;
    logic signed [XB:0]           w_dy;
    logic [XB:0]                  w_ax;
    logic [XB:0]                  w_ay;
    logic [CB:0]                  w_mul_a;
    logic [CB:0]                  w_mul_b;
    logic [CB:0]                  w_prod;
    logic [CB:0]                  w_nc_raw;
    bhct_pkg::t_circle            w_new;
    logic [IW-1:0]                w_slot;
    logic                         w_we;
    logic [IW-1:0]                w_waddr;
    bhct_pkg::t_circle            w_wdata;

    // entry zero reads as its reset contents until first written
    assign w_ent  = (r_idx == '0 && r_e0_init) ? bhct_pkg::RESET_CIRCLE : r_rd;
    assign w_last = (r_idx == IW'(bhct_pkg::MAX_CIRCLES - 1));

    // distance to the observation
    always_comb begin
        w_dx = $signed({r_bx[XB-1], r_bx}) - $signed({w_ent.x[XB-1], w_ent.x});
        w_dy = $signed({r_by[XB-1], r_by}) - $signed({w_ent.y[XB-1], w_ent.y});
        w_ax = w_dx[XB] ? (XB+1)'(-w_dx) : w_dx;
        w_ay = w_dy[XB] ? (XB+1)'(-w_dy) : w_dy;
    end

    // shared certainty multiplier: merge product or decay
    always_comb begin
        w_mul_a = r_inside ? r_recip : {1'b0, r_ent.cert};
        w_mul_b = r_inside ? (bhct_pkg::CERT_ONE - {1'b0, r_ent.cert}) : r_keep;
        w_prod  = bhct_pkg::mul_frac(w_mul_a, w_mul_b);
    end

    // new circle and its slot
    always_comb begin
        w_nc_raw   = bhct_pkg::CERT_ONE - r_recip;
        w_new.cert = (w_nc_raw > bhct_pkg::CERT_MAXV) ? CB'(bhct_pkg::CERT_MAXV) :
                                                          w_nc_raw[CB-1:0];
        w_new.x    = r_bx;
        w_new.y    = r_by;
        w_slot     = r_free_found ? r_free_idx : r_min_idx;
    end

    // memory write port
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_idx;
        w_wdata = '{cert: r_newc, x: r_ent.x, y: r_ent.y};
        if (r_state == bhct_pkg::S_P1_WB && !r_inside) begin
            w_we = 1'b1;
        end else if (r_state == bhct_pkg::S_INS && !r_res_valid && r_has) begin
            w_we    = 1'b1;
            w_waddr = w_slot;
            w_wdata = w_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rd <= r_mem[r_idx];
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bhct_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and request pop
    always_comb begin
        n_state   = r_state;
        o_req_pop = 1'b0;
        unique case (r_state)
            bhct_pkg::S_IDLE: begin
                if (i_req_valid) begin
                    o_req_pop = 1'b1;
                    n_state   = bhct_pkg::S_P1_RD;
                end
            end
            bhct_pkg::S_P1_RD: begin
                if (r_valid[r_idx]) begin
                    n_state = bhct_pkg::S_P1_DIST;
                end else if (w_last) begin
                    n_state = bhct_pkg::S_P2_RD;
                end
            end
            bhct_pkg::S_P1_DIST: n_state = r_has ? bhct_pkg::S_P1_SQ : bhct_pkg::S_P1_MUL;
            bhct_pkg::S_P1_SQ:   n_state = bhct_pkg::S_P1_CMP;
            bhct_pkg::S_P1_CMP:  n_state = bhct_pkg::S_P1_MUL;
            bhct_pkg::S_P1_MUL:  n_state = bhct_pkg::S_P1_WB;
            bhct_pkg::S_P1_WB:   n_state = w_last ? bhct_pkg::S_P2_RD : bhct_pkg::S_P1_RD;
            bhct_pkg::S_P2_RD: begin
                if (r_valid[r_idx]) begin
                    n_state = bhct_pkg::S_P2_CMP;
                end else if (w_last) begin
                    n_state = bhct_pkg::S_INS;
                end
            end
            bhct_pkg::S_P2_CMP:  n_state = w_last ? bhct_pkg::S_INS : bhct_pkg::S_P2_RD;
            bhct_pkg::S_INS: begin
                if (!r_res_valid) begin
                    n_state = bhct_pkg::S_IDLE;
                end
            end
            default: n_state = bhct_pkg::S_IDLE;
        endcase
    end

    // control state: index, valid bits, result slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_valid     <= {{(bhct_pkg::MAX_CIRCLES-1){1'b0}}, 1'b1};
            r_e0_init   <= 1'b1;
            r_res_valid <= 1'b0;
        end else begin
            if (r_res_valid && i_res_pop) begin
                r_res_valid <= 1'b0;
            end
            unique case (r_state)
                bhct_pkg::S_IDLE: r_idx <= '0;
                bhct_pkg::S_P1_RD, bhct_pkg::S_P2_RD: begin
                    if (!r_valid[r_idx]) begin
                        r_idx <= w_last ? '0 : r_idx + 1'b1;
                    end
                end
                bhct_pkg::S_P1_WB: begin
                    if (r_inside || (r_has && r_newc < i_cfg.drop_threshold)) begin
                        r_valid[r_idx] <= 1'b0;
                    end
                    if (!r_inside && r_idx == '0) begin
                        r_e0_init <= 1'b0;
                    end
                    r_idx <= w_last ? '0 : r_idx + 1'b1;
                end
                bhct_pkg::S_P2_CMP: r_idx <= w_last ? '0 : r_idx + 1'b1;
                bhct_pkg::S_INS: begin
                    if (!r_res_valid) begin
                        r_res_valid <= 1'b1;
                        if (r_has) begin
                            r_valid[w_slot] <= 1'b1;
                            if (w_slot == '0) begin
                                r_e0_init <= 1'b0;
                            end
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            bhct_pkg::S_IDLE: begin
                r_has    <= i_req.has_obs;
                r_bx     <= i_req.x;
                r_by     <= i_req.y;
                r_keep   <= bhct_pkg::CERT_ONE - {1'b0, i_cfg.loss_rate};
                r_recip  <= bhct_pkg::CERT_ONE - {1'b0, i_cfg.loss_rate};
                r_rad2   <= i_cfg.merge_radius * i_cfg.merge_radius;
                r_inside <= 1'b0;
            end
            bhct_pkg::S_P1_RD: begin
                if (!r_valid[r_idx] && w_last) begin
                    r_cnt        <= '0;
                    r_free_found <= 1'b0;
                    r_max_found  <= 1'b0;
                    r_min_found  <= 1'b0;
                end
            end
            bhct_pkg::S_P1_DIST: begin
                r_ent    <= w_ent;
                r_far    <= (w_ax >= {2'b0, i_cfg.merge_radius}) ||
                            (w_ay >= {2'b0, i_cfg.merge_radius});
                r_ax     <= w_ax[RW-1:0];
                r_ay     <= w_ay[RW-1:0];
                r_inside <= 1'b0;
            end
            bhct_pkg::S_P1_SQ: begin
                r_sqx <= r_ax * r_ax;
                r_sqy <= r_ay * r_ay;
            end
            bhct_pkg::S_P1_CMP: begin
                r_inside <= !r_far &&
                            (({1'b0, r_sqx} + {1'b0, r_sqy}) < {1'b0, r_rad2});
            end
            bhct_pkg::S_P1_MUL: begin
                if (r_inside) begin
                    r_recip <= w_prod;
                end else begin
                    r_newc <= w_prod[CB-1:0];
                end
            end
            bhct_pkg::S_P1_WB: begin
                if (w_last) begin
                    r_cnt        <= '0;
                    r_free_found <= 1'b0;
                    r_max_found  <= 1'b0;
                    r_min_found  <= 1'b0;
                end
            end
            bhct_pkg::S_P2_RD: begin
                if (!r_valid[r_idx] && !r_free_found) begin
                    r_free_found <= 1'b1;
                    r_free_idx   <= r_idx;
                end
            end
            bhct_pkg::S_P2_CMP: begin
                r_cnt <= r_cnt + 1'b1;
                if (!r_max_found || bhct_pkg::key_less(r_max, w_ent)) begin
                    r_max_found <= 1'b1;
                    r_max       <= w_ent;
                end
                if (!r_min_found || bhct_pkg::key_less(w_ent, r_min)) begin
                    r_min_found <= 1'b1;
                    r_min       <= w_ent;
                    r_min_idx   <= r_idx;
                end
            end
            bhct_pkg::S_INS: begin
                if (!r_res_valid) begin
                    if (r_has) begin
                        if (!r_max_found || bhct_pkg::key_less(r_max, w_new)) begin
                            r_res.est_x <= w_new.x;
                            r_res.est_y <= w_new.y;
                        end else begin
                            r_res.est_x <= r_max.x;
                            r_res.est_y <= r_max.y;
                        end
                        r_res.live_circles <= r_cnt + {{(bhct_pkg::CNT_W-1){1'b0}},
                                                        r_free_found};
                        r_res.evicted      <= !r_free_found;
                    end else begin
                        r_res.est_x        <= r_max_found ? r_max.x : '0;
                        r_res.est_y        <= r_max_found ? r_max.y : '0;
                        r_res.live_circles <= r_cnt;
                        r_res.evicted      <= 1'b0;
                    end
                end
            end
            default: ;
        endcase
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

endmodule

### src/ball_hypothesis_circle_tracker.sv
// Top level of the ball hypothesis circle tracker: ports, registers and assertions.
`timescale 1ns / 1ps
// Observations of one camera frame are pushed one per cycle while full is low;
// only the item flagged frame_end produces a result. The front end takes a new
// item every cycle unless full is high, and hands each frame to the circle engine
// through a two-entry request queue, so full rises only when two frames wait
// behind the one in work. The engine walks the 64-entry circle memory (one read
// port) twice: the merge/decay pass takes each live circle through the read,
// distance, square, compare, multiply and write-back states (square and compare
// are skipped for a frame without an observation) and passes over empty slots,
// the select pass reads and compares each live circle; an insertion step follows.
// The result waits in an output register until popped.
// Configuration writes are always taken and must arrive while the block is idle.
module ball_hypothesis_circle_tracker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_push,
    output logic                             o_full,
    input  logic                             i_has_obs,
    input  logic [bhct_pkg::CERT_BITS-1:0]   i_obs_conf,
    input  logic [bhct_pkg::COORD_BITS-1:0]  i_obs_x,
    input  logic [bhct_pkg::COORD_BITS-1:0]  i_obs_y,
    input  logic                             i_frame_end,
    output logic                             o_empty,
    input  logic                             i_pop,
    output logic [bhct_pkg::COORD_BITS-1:0]  o_est_x,
    output logic [bhct_pkg::COORD_BITS-1:0]  o_est_y,
    output logic [bhct_pkg::CNT_W-1:0]       o_live_circles,
    output logic                             o_evicted,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [bhct_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [bhct_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    bhct_pkg::t_cfg       r_cfg;
    logic                 w_accept;
    logic                 w_req_push;
    bhct_pkg::t_frame_req w_req_in;
    bhct_pkg::t_frame_req w_req_out;
    logic                 w_req_valid;
    logic                 w_req_pop;
    logic                 w_res_valid;
    bhct_pkg::t_result    w_res;

    assign o_cfg_ready = 1'b1;
    assign w_accept    = i_push && !o_full;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.loss_rate      <= bhct_pkg::DECAY_RESET;
            r_cfg.merge_radius   <= bhct_pkg::RADIUS_RESET;
            r_cfg.drop_threshold <= bhct_pkg::THRESHOLD_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (bhct_pkg::t_cfg_idx'(i_cfg_index))
                bhct_pkg::CFG_LOSS_RATE:      r_cfg.loss_rate <= i_cfg_data;
                bhct_pkg::CFG_MERGE_RADIUS:   r_cfg.merge_radius <=
                                                  i_cfg_data[bhct_pkg::RAD_W-1:0];
                bhct_pkg::CFG_DROP_THRESHOLD: r_cfg.drop_threshold <= i_cfg_data;
                bhct_pkg::CFG_UNUSED:         ;
                default:                      ;
            endcase
        end
    end

    bhct_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_has_obs   (i_has_obs),
        .i_obs_conf  (i_obs_conf),
        .i_obs_x     (i_obs_x),
        .i_obs_y     (i_obs_y),
        .i_frame_end (i_frame_end),
        .o_req_push  (w_req_push),
        .o_req       (w_req_in)
    );

    bhct_req_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_req_push),
        .i_req   (w_req_in),
        .o_full  (o_full),
        .i_pop   (w_req_pop),
        .o_valid (w_req_valid),
        .o_req   (w_req_out)
    );

    bhct_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_req_valid (w_req_valid),
        .i_req       (w_req_out),
        .o_req_pop   (w_req_pop),
        .o_res_valid (w_res_valid),
        .o_res       (w_res),
        .i_res_pop   (i_pop)
    );

    assign o_empty        = !w_res_valid;
    assign o_est_x        = w_res.est_x;
    assign o_est_y        = w_res.est_y;
    assign o_live_circles = w_res.live_circles;
    assign o_evicted      = w_res.evicted;

`ifndef SYNTHESIS
    // an eviction only happens on a full table
    a_evict_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && o_evicted) |->
            (o_live_circles == bhct_pkg::CNT_W'(bhct_pkg::MAX_CIRCLES)))
        else $error("eviction reported without a full table");

    // live count never exceeds the table
    a_live_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty |-> (o_live_circles <= bhct_pkg::CNT_W'(bhct_pkg::MAX_CIRCLES)))
        else $error("live circle count out of range");

    // a frame request is only taken from a non-empty queue
    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_req_pop |-> w_req_valid)
        else $error("frame request popped from empty queue");
`endif

endmodule
